// File: design/fls_pkg.sv
`default_nettype none

package fls_pkg;

  // Pool geometry
  localparam int unsigned PoolSlots = 64;
  localparam int unsigned SlotW     = $clog2(PoolSlots);
  localparam int unsigned LinkW     = SlotW + 1;
  localparam int unsigned CapW      = 7;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 2;

  // Link value that marks the end of the free chain
  localparam logic [LinkW-1:0] LinkNone = LinkW'(PoolSlots);
  localparam logic [CapW-1:0]  CapReset = CapW'(64);
  localparam logic [CapW-1:0]  CapMax   = CapW'(PoolSlots);

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESET   = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_SLOT  = 2'd3
  } status_e;

  // Command from the control logic to the link store
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic [LinkW-1:0] wr_data;
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
  } link_cmd_t;

  // Clamp a programmed capacity into 1..PoolSlots
  function automatic logic [CapW-1:0] clamp_cap(input logic [CapW-1:0] cap);
    logic [CapW-1:0] res;
    res = cap;
    if (cap == '0) begin
      res = CapW'(1);
    end else if (cap > CapMax) begin
      res = CapMax;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/fls_if.sv
`default_nettype none

// Request channel: operation and slot
interface fls_req_if import fls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SlotW-1:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

// Response channel: granted slot, live count and status
interface fls_rsp_if import fls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SlotW-1:0]   granted_slot;
  logic [CapW-1:0]    live_slots;
  logic [StatusW-1:0] status;

  modport source (output valid, output granted_slot, output live_slots, output status,
                  input ready);
  modport sink   (input valid, input granted_slot, input live_slots, input status,
                  output ready);
endinterface

// Configuration channel: capacity register write
interface fls_cfg_if import fls_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

// File: design/fls_link_store.sv
`default_nettype none

// Link memory with one synchronous read port and one write port.
// An entry not written since the last pool rebuild reads as its chained
// default: the next slot below capacity, else the end marker.
module fls_link_store import fls_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire link_cmd_t        cmd_i,
  input  wire logic [CapW-1:0]  cap_i,
  output logic      [LinkW-1:0] rd_link_o
);

  logic [LinkW-1:0]     mem [PoolSlots];
  logic [PoolSlots-1:0] vld_q;
  logic [PoolSlots-1:0] vld_d;
  logic [LinkW-1:0]     rd_data_q;
  logic [SlotW-1:0]     rd_addr_q;
  logic                 rd_vld_q;
  logic [LinkW-1:0]     dflt_link;

  // Write and read the link array
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
      rd_addr_q <= cmd_i.rd_addr;
    end
  end

  // Track which entries hold a written link
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.clear) begin
      vld_d = '0;
    end else if (cmd_i.wr_en) begin
      vld_d[cmd_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[cmd_i.rd_addr];
      end
    end
  end

  // Chained default for an unwritten entry
  always_comb begin
    dflt_link = LinkW'(rd_addr_q) + LinkW'(1);
    if (CapW'(dflt_link) >= cap_i) begin
      dflt_link = LinkNone;
    end
  end

  assign rd_link_o = rd_vld_q ? rd_data_q : dflt_link;

endmodule

`default_nettype wire

// File: design/free_list_slot_allocator_unit.sv
`default_nettype none

// Free-list slot allocator: a LIFO pool of up to 64 slots.
// Channels: req_i carries one word per operation (kind, slot); rsp_o returns
// exactly one word per request (granted_slot, live_slots, status); cfg_i
// writes the capacity register, which takes effect at the next reset-pool.
// Release, reset-pool, no-op and rejected allocates answer in the cycle
// after acceptance: one word per cycle while the receiver does not stall.
// A successful allocate answers from S_POP, taking no request before then:
// the head advances to the popped slot's link, which must first come back
// from the link memory's synchronous read port. On reset-pool, per-entry
// valid bits in the link store fall back to the chained default, so no sweep of the memory is needed.
// Block reset leaves an empty pool of 64 free slots, head at slot 0.
// The response sits in an output register; while the receiver stalls it
// holds there, and a new request is taken only once it drains or is being
// taken in the same cycle.
module free_list_slot_allocator_unit import fls_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fls_req_if.sink   req_i,
  fls_rsp_if.source rsp_o,
  fls_cfg_if.sink   cfg_i
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  state_e               state_q, state_d;
  logic [LinkW-1:0]     head_q, head_d;
  logic [CapW-1:0]      count_q, count_d;
  logic [PoolSlots-1:0] free_q, free_d;
  logic [CapW-1:0]      cap_cfg_q, cap_cfg_d;
  logic [CapW-1:0]      active_cap_q, active_cap_d;
  logic                 out_valid_q, out_valid_d;
  logic [SlotW-1:0]     out_granted_q, out_granted_d;
  logic [CapW-1:0]      out_live_q, out_live_d;
  status_e              out_status_q, out_status_d;

  link_cmd_t            link_cmd;
  logic [LinkW-1:0]     rd_link;
  logic                 req_fire;
  logic [SlotW-1:0]     head_slot;

  fls_link_store u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (link_cmd),
    .cap_i     (active_cap_q),
    .rd_link_o (rd_link)
  );

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign head_slot   = head_q[SlotW-1:0];

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_slot = out_granted_q;
  assign rsp_o.live_slots   = out_live_q;
  assign rsp_o.status       = out_status_q;

  // Decide the operation and the next state of the pool
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    free_d        = free_q;
    active_cap_d  = active_cap_q;
    cap_cfg_d     = cap_cfg_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_granted_d = out_granted_q;
    out_live_d    = out_live_q;
    out_status_d  = out_status_q;
    link_cmd      = '0;

    // Latch a capacity write
    if (cfg_i.valid && cfg_i.ready) begin
      cap_cfg_d = cfg_i.capacity_in_use;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          out_valid_d   = 1'b1;
          out_granted_d = '0;
          out_live_d    = count_q;
          out_status_d  = ST_OK;
          case (kind_e'(req_i.kind))
            KIND_ALLOC: begin
              if (count_q >= active_cap_q || head_q[SlotW]) begin
                out_status_d = ST_EXHAUSTED;
              end else begin
                // Fetch the head's link; answer once it returns
                out_valid_d      = 1'b0;
                link_cmd.rd_en   = 1'b1;
                link_cmd.rd_addr = head_slot;
                state_d          = S_POP;
              end
            end
            KIND_RELEASE: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (CapW'(req_i.slot) >= active_cap_q || free_q[req_i.slot]) begin
                out_status_d = ST_BAD_SLOT;
              end else begin
                // Push the slot as the new head
                link_cmd.wr_en      = 1'b1;
                link_cmd.wr_addr    = req_i.slot;
                link_cmd.wr_data    = head_q;
                free_d[req_i.slot]  = 1'b1;
                head_d              = LinkW'(req_i.slot);
                count_d             = count_q - CapW'(1);
                out_live_d          = count_q - CapW'(1);
              end
            end
            KIND_RESET: begin
              // Rebuild the chain from the capacity register
              link_cmd.clear = 1'b1;
              active_cap_d   = clamp_cap(cap_cfg_q);
              free_d         = '1;
              head_d         = '0;
              count_d        = '0;
              out_live_d     = '0;
            end
            default: begin
              out_live_d = count_q;
            end
          endcase
        end
      end
      S_POP: begin
        // Advance the head and hand out the popped slot
        head_d            = rd_link;
        free_d[head_slot] = 1'b0;
        count_d           = count_q + CapW'(1);
        out_valid_d       = 1'b1;
        out_granted_d     = head_slot;
        out_live_d        = count_q + CapW'(1);
        out_status_d      = ST_OK;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      free_q       <= '1;
      cap_cfg_q    <= CapReset;
      active_cap_q <= clamp_cap(CapReset);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      free_q       <= free_d;
      cap_cfg_q    <= cap_cfg_d;
      active_cap_q <= active_cap_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_granted_q <= out_granted_d;
    out_live_q    <= out_live_d;
    out_status_q  <= out_status_d;
  end

endmodule

`default_nettype wire

// File: design/fls_checker.sv
`default_nettype none

module fls_checker import fls_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic [KindW-1:0]   req_kind_i,
  input wire logic               rsp_valid_i,
  input wire logic               rsp_ready_i,
  input wire logic [SlotW-1:0]   rsp_granted_i,
  input wire logic [CapW-1:0]    rsp_live_i,
  input wire logic [StatusW-1:0] rsp_status_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // A stalled response word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_i)
      && $stable(rsp_live_i) && $stable(rsp_status_i))
    else $error("stalled response changed");

  // No request is taken while an earlier answer is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> !rsp_valid_i || rsp_ready_i)
    else $error("request taken over a stalled response");

  // A failed operation grants nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_granted_i == '0)
    else $error("slot granted with error status");

  // Live count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_live_i <= CapMax)
    else $error("live count beyond pool size");

  // Reset-pool answers next cycle with an empty pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_kind_i == KIND_RESET |=> rsp_valid_i && rsp_live_i == '0
      && rsp_status_i == ST_OK)
    else $error("reset-pool response wrong");

endmodule

bind free_list_slot_allocator_unit fls_checker u_fls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_kind_i    (req_i.kind),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_granted_i (rsp_o.granted_slot),
  .rsp_live_i    (rsp_o.live_slots),
  .rsp_status_i  (rsp_o.status)
);

`default_nettype wire
